// ===== design/pbpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet buffer pool manager package
// Shared command, result, decode and configuration types and codes.
// ----------------------------------------------------------------------------
package pbpm_pkg;

	localparam logic [2:0] MODE_ALLOC = 3'd0;
	localparam logic [2:0] MODE_REF   = 3'd1;
	localparam logic [2:0] MODE_FREE  = 3'd2;
	localparam logic [2:0] MODE_PUSH  = 3'd3;
	localparam logic [2:0] MODE_PULL  = 3'd4;
	localparam logic [2:0] MODE_PUT   = 3'd5;
	localparam logic [2:0] MODE_LEN   = 3'd6;

	localparam logic CFG_BUFS = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  buffer_index;
		logic [11:0] amount;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [5:0]  result_index;
		logic [16:0] byte_address;
		logic [11:0] data_length;
		logic [6:0]  free_buffers;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  idx;
		logic [11:0] amount;
		logic        bad;
	} dec_t;

	typedef struct packed {
		logic [6:0]  bufs;
		logic [11:0] size;
	} cfg_t;

endpackage

// ===== design/pbpm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/pbpm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool manager front end
// Accepts command transactions and classifies them for the back end.
// ----------------------------------------------------------------------------
module pbpm_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  pbpm_pkg::cmd_t    in_data,
	input  logic [6:0]        bufs,
	input  logic              q_full,
	output logic              q_push,
	output pbpm_pkg::dec_t    q_data
);
	logic idx_ok;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign idx_ok   = {1'b0, in_data.buffer_index} < bufs;

	always_comb begin
		q_data.mode   = in_data.mode;
		q_data.idx    = in_data.buffer_index;
		q_data.amount = in_data.amount;
		unique case (in_data.mode)
			pbpm_pkg::MODE_ALLOC: q_data.bad = 1'b0;
			pbpm_pkg::MODE_REF,
			pbpm_pkg::MODE_FREE,
			pbpm_pkg::MODE_PUSH,
			pbpm_pkg::MODE_PULL,
			pbpm_pkg::MODE_PUT,
			pbpm_pkg::MODE_LEN: q_data.bad = !idx_ok;
			default: q_data.bad = 1'b1;
		endcase
	end
endmodule

// ===== design/pbpm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool manager command queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module pbpm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pbpm_pkg::dec_t    wdata,
	input  logic              pop,
	output pbpm_pkg::dec_t    rdata,
	output logic              full,
	output logic              empty
);
	pbpm_pkg::dec_t slot_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

// ===== design/pbpm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool manager back end
// Reads a buffer entry, applies the command and writes it back.
// ----------------------------------------------------------------------------
module pbpm_back #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbpm_pkg::cfg_t    cfg,
	input  logic              reinit,
	input  logic [6:0]        reinit_bufs,
	input  logic              q_empty,
	input  pbpm_pkg::dec_t    q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output pbpm_pkg::rsp_t    out_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t          state_q;
	pbpm_pkg::dec_t  cmd_q;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] busy_q;
	logic            rvld_q;
	logic [6:0]      ftot_q;
	logic            out_valid_q;
	pbpm_pkg::rsp_t  out_q;

	logic [31:0]     rdata;
	logic [7:0]      cnt;
	logic [11:0]     d;
	logic [11:0]     t;
	logic            hit;
	logic [AW-1:0]   found;
	logic            can_out;
	logic            done;

	logic            fail;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [7:0]      cnt_n;
	logic [11:0]     d_n;
	logic [11:0]     t_n;
	logic [6:0]      ftot_n;
	logic [11:0]     offset;
	logic [5:0]      idx_out;
	logic            len_ok;
	logic [17:0]     prod;
	logic [16:0]     addr;

	pbpm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({cnt_n, d_n, t_n}),
		.re    (q_pop),
		.raddr (q_data.idx[AW-1:0]),
		.rdata (rdata)
	);

	assign q_pop   = (state_q == S_IDLE) && !q_empty;
	assign can_out = !out_valid_q || out_ready;
	assign done    = (state_q == S_EXEC) && can_out;

	assign cnt = rvld_q ? rdata[31:24] : 8'd0;
	assign d   = rvld_q ? rdata[23:12] : 12'd0;
	assign t   = rvld_q ? rdata[11:0]  : 12'd0;

	always_comb begin
		hit   = 1'b0;
		found = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!busy_q[i] && (7'(i) < cfg.bufs)) begin
				hit   = 1'b1;
				found = AW'(i);
			end
		end
	end

	always_comb begin
		fail    = cmd_q.bad;
		we      = 1'b0;
		waddr   = cmd_q.idx[AW-1:0];
		cnt_n   = cnt;
		d_n     = d;
		t_n     = t;
		ftot_n  = ftot_q;
		offset  = d;
		idx_out = cmd_q.idx;
		len_ok  = {1'b0, cmd_q.idx} < cfg.bufs;
		if (cmd_q.mode == pbpm_pkg::MODE_ALLOC) begin
			idx_out = '0;
			fail    = (ftot_q == 7'd0) || !hit;
			len_ok  = !fail;
			if (!fail) begin
				idx_out = 6'(found);
				waddr   = found;
				we      = done;
				offset  = (cmd_q.amount > cfg.size) ? 12'd0 : cmd_q.amount;
				d_n     = offset;
				t_n     = offset;
				cnt_n   = 8'd1;
				ftot_n  = ftot_q - 7'd1;
			end
		end else if (!cmd_q.bad) begin
			unique case (cmd_q.mode)
				pbpm_pkg::MODE_REF: begin
					if (cnt != 8'd255) begin
						cnt_n = cnt + 8'd1;
					end
					we = done;
				end
				pbpm_pkg::MODE_FREE: begin
					if (cnt == 8'd0) begin
						fail = 1'b1;
					end else begin
						cnt_n = cnt - 8'd1;
						if (cnt == 8'd1) begin
							d_n = '0;
							t_n = '0;
							if (ftot_q < cfg.bufs) begin
								ftot_n = ftot_q + 7'd1;
							end
						end
						offset = d_n;
						we     = done;
					end
				end
				pbpm_pkg::MODE_PUSH: begin
					if (d < cmd_q.amount) begin
						fail = 1'b1;
					end else begin
						d_n    = d - cmd_q.amount;
						offset = d_n;
						we     = done;
					end
				end
				pbpm_pkg::MODE_PULL: begin
					if ((t - d) < cmd_q.amount) begin
						fail = 1'b1;
					end else begin
						d_n    = d + cmd_q.amount;
						offset = d_n;
						we     = done;
					end
				end
				pbpm_pkg::MODE_PUT: begin
					if ((cfg.size - t) < cmd_q.amount) begin
						fail = 1'b1;
					end else begin
						t_n    = t + cmd_q.amount;
						offset = t;
						we     = done;
					end
				end
				default: begin
					offset = d;
				end
			endcase
		end
		if (fail) begin
			we     = 1'b0;
			cnt_n  = cnt;
			d_n    = d;
			t_n    = t;
			ftot_n = ftot_q;
		end
	end

	assign prod = idx_out * cfg.size;
	assign addr = prod[16:0] + {5'd0, offset};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (done) begin
			out_q.status       <= fail;
			out_q.result_index <= idx_out;
			out_q.byte_address <= fail ? 17'd0 : addr;
			out_q.data_length  <= len_ok ? (t_n - d_n) : 12'd0;
			out_q.free_buffers <= ftot_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			busy_q      <= '0;
			rvld_q      <= 1'b0;
			ftot_q      <= 7'(DEPTH);
			out_valid_q <= 1'b0;
		end else if (reinit) begin
			vld_q  <= '0;
			busy_q <= '0;
			ftot_q <= reinit_bufs;
		end else begin
			if (q_pop) begin
				rvld_q <= vld_q[q_data.idx[AW-1:0]];
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (can_out) begin
						ftot_q <= ftot_n;
						if (we) begin
							vld_q[waddr]  <= 1'b1;
							busy_q[waddr] <= cnt_n != 8'd0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== design/packet_buffer_pool_manager_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet buffer pool manager
// Reference-counted pool of fixed-size packet buffers with headroom offsets.
// ----------------------------------------------------------------------------
// The back end finishes each command before it takes the next: in S_IDLE it
// reads the buffer entry memory, and in S_EXEC it updates the entry and loads
// the result register, waiting there while the previous result is not yet
// taken. A two-entry queue lets new commands be accepted while a result
// waits. Reset and any configuration write reinitialize the pool at once
// through per-entry valid bits, with no clearing pass.
module packet_buffer_pool_manager_top #(
	parameter int NUM_BUFS  = 64,
	parameter int BUF_BYTES = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pbpm_pkg::cmd_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pbpm_pkg::rsp_t    out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [11:0]       cfg_data
);
	localparam int IDX_LIMIT  = (NUM_BUFS < 64) ? NUM_BUFS : 64;
	localparam int SIZE_LIMIT = (BUF_BYTES < 2048) ? BUF_BYTES : 2048;

	pbpm_pkg::cfg_t cfg_q;
	logic           reinit;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	pbpm_pkg::dec_t q_wdata;
	pbpm_pkg::dec_t q_rdata;
	logic [6:0]     bufs_v;
	logic [11:0]    size_v;
	logic [6:0]     bufs_next;

	assign cfg_ready = 1'b1;
	assign reinit    = cfg_valid;
	assign bufs_next = (cfg_index == pbpm_pkg::CFG_BUFS) ? bufs_v : cfg_q.bufs;

	always_comb begin
		bufs_v = cfg_data[6:0];
		if (bufs_v == 7'd0) begin
			bufs_v = 7'd1;
		end
		if (bufs_v > 7'(IDX_LIMIT)) begin
			bufs_v = 7'(IDX_LIMIT);
		end
		size_v = cfg_data;
		if (size_v == 12'd0) begin
			size_v = 12'd1;
		end
		if (size_v > 12'(SIZE_LIMIT)) begin
			size_v = 12'(SIZE_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bufs <= 7'(IDX_LIMIT);
			cfg_q.size <= 12'(SIZE_LIMIT);
		end else if (cfg_valid) begin
			if (cfg_index == pbpm_pkg::CFG_BUFS) begin
				cfg_q.bufs <= bufs_v;
			end else begin
				cfg_q.size <= size_v;
			end
		end
	end

	pbpm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.bufs     (cfg_q.bufs),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	pbpm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	pbpm_back #(.DEPTH(IDX_LIMIT)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.reinit      (reinit),
		.reinit_bufs (bufs_next),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);
endmodule
